// File: rtl/tfb_pkg.sv
// tfb_pkg: shared types, constants and the crc-16 byte update for the frame builder
// used by every module of tlv_frame_builder_crc16; depends on nothing
package tfb_pkg;

    // frame layout
    localparam int HDR_BYTES         = 2 + 1 + 1 + 1 + 2 + 4 + 4;
    localparam int ACK_PAYLOAD_BYTES = 9;
    localparam int CRC_BYTES         = 2;
    localparam int MAX_RESULTS       = HDR_BYTES + ACK_PAYLOAD_BYTES + CRC_BYTES;
    localparam int IDX_W             = $clog2(MAX_RESULTS);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // request actions
    localparam logic [1:0] ACT_HEADER = 2'd0;
    localparam logic [1:0] ACT_DATA   = 2'd1;
    localparam logic [1:0] ACT_ACK    = 2'd2;

    // register indexes
    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_ACK_VERSION = 2'd2;
    localparam logic [1:0] REG_ACK_COMMAND = 2'd3;

    localparam int PADDR_W = 4;

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [1:0] {
        KIND_HDR,
        KIND_DATA,
        KIND_ACK
    } t_kind;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         version;
        logic [7:0]         command;
        logic [7:0]         flag_bits;
        logic [15:0]        payload_length;
        logic [31:0]        sequence_req;
        logic [31:0]        time_ms;
        logic [7:0]         data_byte;
        logic [7:0]         acked_command;
        logic [31:0]        acked_sequence;
        logic signed [15:0] ack_status;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } t_out_req;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] ack_version;
        logic [7:0] ack_command;
    } t_cfg;

    // one unit of work for the serializer
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  version;
        logic [7:0]  command;
        logic [7:0]  flag_bits;
        logic [15:0] length;
        logic [31:0] seq;
        logic [31:0] tms;
        logic [7:0]  data_byte;
        logic [7:0]  acked_command;
        logic [31:0] acked_sequence;
        logic [15:0] ack_status;
        t_idx        last;
        logic        has_crc;
    } t_job;

    // crc-16/ccitt-false update with one byte, msb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/tfb_cfg.sv
// tfb_cfg: apb register file holding sync bytes and ack version/command
// depends on tfb_pkg
module tfb_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tfb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output tfb_pkg::t_cfg               o_cfg
);
    import tfb_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= 8'hAA;
            r_cfg.sync_second <= 8'h55;
            r_cfg.ack_version <= 8'h01;
            r_cfg.ack_command <= 8'h80;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SYNC_FIRST:  r_cfg.sync_first  <= pwdata[7:0];
                REG_SYNC_SECOND: r_cfg.sync_second <= pwdata[7:0];
                REG_ACK_VERSION: r_cfg.ack_version <= pwdata[7:0];
                REG_ACK_COMMAND: r_cfg.ack_command <= pwdata[7:0];
                default:         r_cfg.sync_first  <= r_cfg.sync_first;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_SYNC_FIRST:  prdata = {24'd0, r_cfg.sync_first};
            REG_SYNC_SECOND: prdata = {24'd0, r_cfg.sync_second};
            REG_ACK_VERSION: prdata = {24'd0, r_cfg.ack_version};
            REG_ACK_COMMAND: prdata = {24'd0, r_cfg.ack_command};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/tfb_ctrl.sv
// tfb_ctrl: request acceptance, open-frame tracking and job building
// depends on tfb_pkg
module tfb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  tfb_pkg::t_in_req i_in_req,
    input  tfb_pkg::t_cfg    i_cfg,
    input  logic             i_ser_ready,
    output logic             o_job_valid,
    output tfb_pkg::t_job    o_job
);
    import tfb_pkg::*;

    logic        r_frame_open;
    logic [15:0] r_bytes_left;
    logic        n_frame_open;
    logic [15:0] n_bytes_left;
    logic        accept;
    logic        has_out;
    t_job        job;

    assign accept     = i_in_valid && i_ser_ready;
    assign o_in_stall = !i_ser_ready;

    // decode the request into a job and the next frame state
    always_comb begin
        job                = '0;
        job.kind           = KIND_HDR;
        job.version        = i_in_req.version;
        job.command        = i_in_req.command;
        job.flag_bits      = i_in_req.flag_bits;
        job.length         = i_in_req.payload_length;
        job.seq            = i_in_req.sequence_req;
        job.tms            = i_in_req.time_ms;
        job.data_byte      = i_in_req.data_byte;
        job.acked_command  = i_in_req.acked_command;
        job.acked_sequence = i_in_req.acked_sequence;
        job.ack_status     = i_in_req.ack_status;
        n_frame_open       = r_frame_open;
        n_bytes_left       = r_bytes_left;
        has_out            = 1'b0;
        unique case (i_in_req.action)
            ACT_HEADER: begin
                has_out      = 1'b1;
                n_bytes_left = i_in_req.payload_length;
                n_frame_open = (i_in_req.payload_length != 16'd0);
                if (i_in_req.payload_length == 16'd0) begin
                    job.last    = t_idx'(HDR_BYTES + CRC_BYTES - 1);
                    job.has_crc = 1'b1;
                end else begin
                    job.last    = t_idx'(HDR_BYTES - 1);
                    job.has_crc = 1'b0;
                end
            end
            ACT_DATA: begin
                job.kind = KIND_DATA;
                if (r_frame_open) begin
                    has_out      = 1'b1;
                    n_bytes_left = r_bytes_left - 16'd1;
                    if (r_bytes_left == 16'd1) begin
                        n_frame_open = 1'b0;
                        job.last     = t_idx'(CRC_BYTES);
                        job.has_crc  = 1'b1;
                    end else begin
                        job.last    = '0;
                        job.has_crc = 1'b0;
                    end
                end
            end
            ACT_ACK: begin
                has_out       = 1'b1;
                job.kind      = KIND_ACK;
                job.version   = i_cfg.ack_version;
                job.command   = i_cfg.ack_command;
                job.flag_bits = 8'd0;
                job.length    = 16'(ACK_PAYLOAD_BYTES);
                job.last      = t_idx'(MAX_RESULTS - 1);
                job.has_crc   = 1'b1;
                n_frame_open  = 1'b0;
                n_bytes_left  = 16'd0;
            end
            default: begin
                has_out = 1'b0;
            end
        endcase
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_bytes_left <= 16'd0;
        end else if (accept) begin
            r_frame_open <= n_frame_open;
            r_bytes_left <= n_bytes_left;
        end
    end

    assign o_job_valid = accept && has_out;
    assign o_job       = job;

    // an open frame always has bytes outstanding
    a_open_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_open == (r_bytes_left != 16'd0))
        else $error("frame open flag disagrees with byte count");

    // a dropped payload byte or an ignored action leaves the frame state alone
    a_drop_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !has_out) |=> ($stable(r_frame_open) && $stable(r_bytes_left)))
        else $error("dropped request changed frame state");

    // a job is only handed over when the serializer can take it
    a_job_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> i_ser_ready)
        else $error("job issued while serializer busy");

endmodule

// File: rtl/tfb_ser.sv
// tfb_ser: byte serializer with running crc and output register
// depends on tfb_pkg
module tfb_ser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tfb_pkg::t_cfg     i_cfg,
    input  logic              i_job_valid,
    input  tfb_pkg::t_job     i_job,
    output logic              o_ready,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tfb_pkg::t_out_req o_out_req
);
    import tfb_pkg::*;

    t_job        r_job;
    logic        r_busy;
    t_idx        r_idx;
    logic [15:0] r_crc;
    logic        r_out_valid;
    t_out_req    r_out;

    logic        out_ready;
    logic        step;
    logic        at_last;
    logic        crc_lo;
    logic        crc_hi;
    t_idx        ack_ofs;
    logic [7:0]  fld_byte;
    logic [7:0]  cur_byte;
    logic [15:0] n_crc;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign step      = r_busy && out_ready;
    assign at_last   = (r_idx == r_job.last);
    assign o_ready   = !r_busy || (step && at_last);
    assign crc_hi    = r_job.has_crc && at_last;
    assign crc_lo    = r_job.has_crc && (r_idx == r_job.last - t_idx'(1));
    assign ack_ofs   = r_idx - t_idx'(HDR_BYTES);

    // pick the frame byte at the current position
    always_comb begin
        fld_byte = 8'd0;
        if (r_job.kind == KIND_DATA) begin
            fld_byte = r_job.data_byte;
        end else begin
            unique case (r_idx)
                t_idx'(0):  fld_byte = i_cfg.sync_first;
                t_idx'(1):  fld_byte = i_cfg.sync_second;
                t_idx'(2):  fld_byte = r_job.version;
                t_idx'(3):  fld_byte = r_job.command;
                t_idx'(4):  fld_byte = r_job.flag_bits;
                t_idx'(5):  fld_byte = r_job.length[7:0];
                t_idx'(6):  fld_byte = r_job.length[15:8];
                t_idx'(7):  fld_byte = r_job.seq[7:0];
                t_idx'(8):  fld_byte = r_job.seq[15:8];
                t_idx'(9):  fld_byte = r_job.seq[23:16];
                t_idx'(10): fld_byte = r_job.seq[31:24];
                t_idx'(11): fld_byte = r_job.tms[7:0];
                t_idx'(12): fld_byte = r_job.tms[15:8];
                t_idx'(13): fld_byte = r_job.tms[23:16];
                t_idx'(14): fld_byte = r_job.tms[31:24];
                default: begin
                    // ack payload, zero fill after the status word
                    unique case (ack_ofs)
                        t_idx'(0): fld_byte = r_job.acked_command;
                        t_idx'(1): fld_byte = r_job.acked_sequence[7:0];
                        t_idx'(2): fld_byte = r_job.acked_sequence[15:8];
                        t_idx'(3): fld_byte = r_job.acked_sequence[23:16];
                        t_idx'(4): fld_byte = r_job.acked_sequence[31:24];
                        t_idx'(5): fld_byte = r_job.ack_status[7:0];
                        t_idx'(6): fld_byte = r_job.ack_status[15:8];
                        default:   fld_byte = 8'd0;
                    endcase
                end
            endcase
        end
    end

    // crc trailer overrides, and next running crc
    always_comb begin
        cur_byte = fld_byte;
        n_crc    = r_crc;
        priority if (crc_hi) begin
            cur_byte = r_crc[15:8];
            n_crc    = CRC_INIT;
        end else if (crc_lo) begin
            cur_byte = r_crc[7:0];
        end else if (r_job.kind != KIND_DATA && r_idx < t_idx'(2)) begin
            n_crc = CRC_INIT;
        end else begin
            n_crc = crc16_byte(r_crc, fld_byte);
        end
    end

    // job register and byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_job_valid) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (step && at_last) begin
            r_busy <= 1'b0;
        end else if (step) begin
            r_idx <= r_idx + t_idx'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_valid) begin
            r_job <= i_job;
        end
    end

    // running crc
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else if (step) begin
            r_crc <= n_crc;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.out_byte  <= cur_byte;
            r_out.frame_end <= crc_hi;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // position never runs past the job's last byte
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_job.last))
        else $error("byte position beyond end of job");

    // a new job only lands when the current one is done or finishing
    a_load_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> (!r_busy || (step && at_last)))
        else $error("job overwritten while in progress");

    // header and ack jobs always start from a fresh crc after the sync bytes
    a_crc_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_job.kind != KIND_DATA && r_idx == t_idx'(1)) |=> (r_crc == CRC_INIT))
        else $error("crc not initialized after sync bytes");

    // ack jobs never end without a crc trailer
    a_crc_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_job.has_crc) |-> (r_job.kind != KIND_ACK))
        else $error("ack job without crc trailer");

endmodule

// File: rtl/tlv_frame_builder_crc16.sv
// tlv_frame_builder_crc16: a request goes to the serializer's job register and its bytes
// leave through the output register, one per cycle while the output is not stalled. a
// payload byte gives one byte, three when it closes the frame; a header fifteen (seventeen
// for zero length) and an ack frame twenty-six. the next request is taken with the last byte.
// synchronous active-low reset clears the frame state, crc to 0xffff and config to defaults
module tlv_frame_builder_crc16 (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  tfb_pkg::t_in_req            i_in_req,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output tfb_pkg::t_out_req           o_out_req,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tfb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import tfb_pkg::*;

    t_cfg cfg;
    logic ser_ready;
    logic job_valid;
    t_job job;

    // configuration registers
    tfb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // request decode and frame tracking
    tfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .i_cfg       (cfg),
        .i_ser_ready (ser_ready),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    // byte serializer
    tfb_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_ready     (ser_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

endmodule

// File: test/tb_top.sv
// tb_top: self-checking testbench for tlv_frame_builder_crc16, predicts every serialized
// frame byte and crc, and compares it with the block output while both sides stall at random
// depends on tfb_pkg and the tlv_frame_builder_crc16 rtl
module tb_top;
    import tfb_pkg::*;

    // request action that the block ignores
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 32;
    localparam int MAX_SHOWN     = 40;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    t_in_req            in_req    = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out_req           out_req;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;

    // predicted block state and register copy
    logic [7:0]  cfg_model [4];
    logic        frame_active = 1'b0;
    logic [15:0] bytes_due    = '0;
    logic [15:0] crc_acc      = CRC_INIT;

    t_out_req frame_bytes_q[$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  cycles     = 0;
    bit  quiet      = 1'b0;
    int  stall_run  = 0;
    int  free_run   = 0;

    tlv_frame_builder_crc16 DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    initial begin
        forever #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tlv_frame_builder_crc16 regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("mismatch: %s got 0x%0h expected 0x%0h (cycle %0d)",
                     what, got, want, cycles);
    endtask

    // crc-16 ccitt-false, one input bit at a time
    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last);
        t_out_req e;
        e.out_byte  = b;
        e.frame_end = last;
        frame_bytes_q = {frame_bytes_q, e};
    endtask

    task automatic push_crc_byte(input logic [7:0] b);
        crc_acc = crc_next(crc_acc, b);
        push_byte(b, 1'b0);
    endtask

    // sync bytes, then the crc-covered header fields little-endian
    task automatic push_header(input logic [7:0] ver, input logic [7:0] cmd,
                               input logic [7:0] flg, input logic [15:0] len,
                               input logic [31:0] seq, input logic [31:0] tms);
        crc_acc = CRC_INIT;
        push_byte(cfg_model[REG_SYNC_FIRST], 1'b0);
        push_byte(cfg_model[REG_SYNC_SECOND], 1'b0);
        push_crc_byte(ver);
        push_crc_byte(cmd);
        push_crc_byte(flg);
        for (int i = 0; i < 2; i++) push_crc_byte(len[8*i +: 8]);
        for (int i = 0; i < 4; i++) push_crc_byte(seq[8*i +: 8]);
        for (int i = 0; i < 4; i++) push_crc_byte(tms[8*i +: 8]);
    endtask

    // crc low byte first, frame closed
    task automatic push_trailer;
        push_byte(crc_acc[7:0], 1'b0);
        push_byte(crc_acc[15:8], 1'b1);
        frame_active = 1'b0;
        bytes_due    = '0;
        crc_acc      = CRC_INIT;
    endtask

    task automatic predict_bytes(input t_in_req r, output int produced);
        int start_size;
        start_size = frame_bytes_q.size();
        case (r.action)
            ACT_HEADER: begin
                push_header(r.version, r.command, r.flag_bits, r.payload_length,
                            r.sequence_req, r.time_ms);
                if (r.payload_length == 16'd0) begin
                    push_trailer();
                end else begin
                    frame_active = 1'b1;
                    bytes_due    = r.payload_length;
                end
            end
            ACT_DATA: begin
                // dropped when no frame is open
                if (frame_active) begin
                    push_crc_byte(r.data_byte);
                    bytes_due = bytes_due - 16'd1;
                    if (bytes_due == 16'd0) push_trailer();
                end
            end
            ACT_ACK: begin
                frame_active = 1'b0;
                bytes_due    = '0;
                push_header(cfg_model[REG_ACK_VERSION], cfg_model[REG_ACK_COMMAND], 8'h00,
                            16'(ACK_PAYLOAD_BYTES), r.sequence_req, r.time_ms);
                push_crc_byte(r.acked_command);
                for (int i = 0; i < 4; i++) push_crc_byte(r.acked_sequence[8*i +: 8]);
                for (int i = 0; i < 2; i++) push_crc_byte(r.ack_status[8*i +: 8]);
                for (int i = 7; i < ACK_PAYLOAD_BYTES; i++) push_crc_byte(8'h00);
                push_trailer();
            end
            default: begin
            end
        endcase
        produced = frame_bytes_q.size() - start_size;
    endtask

    // output checker
    always @(posedge clk) begin
        t_out_req want;
        if (rst_n && out_valid && !out_stall) begin
            if (frame_bytes_q.size() == 0) begin
                report_mismatch("byte with nothing expected", 32'(out_req.out_byte), 32'h0);
            end else begin
                want = frame_bytes_q.pop_front();
                if (out_req.out_byte !== want.out_byte)
                    report_mismatch("out_byte", 32'(out_req.out_byte), 32'(want.out_byte));
                if (out_req.frame_end !== want.frame_end)
                    report_mismatch("frame_end", 32'(out_req.frame_end),
                                    32'(want.frame_end));
            end
        end
    end

    // receiver stall bursts of random length between free stretches of random length
    always @(negedge clk) begin
        if (quiet) begin
            out_stall <= 1'b0;
        end else if (stall_run > 0) begin
            out_stall <= 1'b1;
            stall_run--;
        end else if (free_run > 0) begin
            out_stall <= 1'b0;
            free_run--;
        end else if ($urandom_range(0, 2) == 0) begin
            out_stall <= 1'b1;
            stall_run = $urandom_range(0, 4);
        end else begin
            out_stall <= 1'b0;
            free_run = $urandom_range(0, 15);
        end
    end

    function automatic t_in_req rand_req(input logic [1:0] act);
        t_in_req r;
        r.action         = act;
        r.version        = 8'($urandom);
        r.command        = 8'($urandom);
        r.flag_bits      = 8'($urandom);
        r.payload_length = 16'($urandom_range(1, 8));
        r.sequence_req   = $urandom;
        r.time_ms        = $urandom;
        r.data_byte      = 8'($urandom);
        r.acked_command  = 8'($urandom);
        r.acked_sequence = $urandom;
        r.ack_status     = 16'($urandom);
        return r;
    endfunction

    // one request, entered and left at a falling edge
    task automatic send_req(input t_in_req r);
        int produced;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_bytes(r, produced);
        if (produced > 0) items_sent++;
        @(negedge clk);
    endtask

    // hold off until every predicted byte has come out
    task automatic drain_bytes;
        in_valid <= 1'b0;
        while (frame_bytes_q.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        cfg_model[idx] = val;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_reg(input logic [1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== {24'h0, cfg_model[idx]})
            report_mismatch("register readback", prdata, {24'h0, cfg_model[idx]});
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // registers change only with the block idle
    task automatic apply_config(input logic [7:0] s1, input logic [7:0] s2,
                                input logic [7:0] av, input logic [7:0] ac);
        drain_bytes();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(REG_SYNC_FIRST, s1);
        write_reg(REG_SYNC_SECOND, s2);
        write_reg(REG_ACK_VERSION, av);
        write_reg(REG_ACK_COMMAND, ac);
        check_reg(REG_SYNC_FIRST);
        check_reg(REG_SYNC_SECOND);
        check_reg(REG_ACK_VERSION);
        check_reg(REG_ACK_COMMAND);
    endtask

    // field extremes and each special case with reset register values
    task automatic test_directed_frames;
        t_in_req r;
        // zero-length headers, all fields low then all high
        r = '0;
        r.action = ACT_HEADER;
        send_req(r);
        r = '1;
        r.action = ACT_HEADER;
        r.payload_length = 16'd0;
        send_req(r);
        // short frame with extreme payload bytes
        r = rand_req(ACT_HEADER);
        r.payload_length = 16'd3;
        send_req(r);
        r = rand_req(ACT_DATA);
        r.data_byte = 8'h00;
        send_req(r);
        r.data_byte = 8'hFF;
        send_req(r);
        send_req(rand_req(ACT_DATA));
        // payload with no open frame is dropped
        send_req(rand_req(ACT_DATA));
        // longest length, then cut off by a new header
        r = rand_req(ACT_HEADER);
        r.payload_length = 16'hFFFF;
        send_req(r);
        send_req(rand_req(ACT_DATA));
        send_req(rand_req(ACT_DATA));
        r = rand_req(ACT_HEADER);
        r.payload_length = 16'd1;
        send_req(r);
        send_req(rand_req(ACT_DATA));
        // ack cutting off an open frame, most negative status
        r = rand_req(ACT_HEADER);
        r.payload_length = 16'd4;
        send_req(r);
        send_req(rand_req(ACT_DATA));
        r = '1;
        r.action = ACT_ACK;
        r.ack_status = 16'h8000;
        send_req(r);
        // ack with zero fields, then most positive status
        r = '0;
        r.action = ACT_ACK;
        send_req(r);
        r = rand_req(ACT_ACK);
        r.ack_status = 16'h7FFF;
        send_req(r);
        // payload after an ack is dropped, unused action is ignored
        send_req(rand_req(ACT_DATA));
        send_req(rand_req(ACT_NONE));
        // ignored action inside an open frame leaves it open
        r = rand_req(ACT_HEADER);
        r.payload_length = 16'd2;
        send_req(r);
        send_req(rand_req(ACT_NONE));
        send_req(rand_req(ACT_DATA));
        send_req(rand_req(ACT_DATA));
    endtask

    task automatic short_frame_and_ack;
        t_in_req r;
        r = rand_req(ACT_HEADER);
        r.payload_length = 16'd2;
        send_req(r);
        send_req(rand_req(ACT_DATA));
        send_req(rand_req(ACT_DATA));
        send_req(rand_req(ACT_ACK));
    endtask

    // register extremes
    task automatic test_config_extremes;
        apply_config(8'h00, 8'h00, 8'h00, 8'h00);
        short_frame_and_ack();
        apply_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        short_frame_and_ack();
    endtask

    // mostly well-formed frames with random content, plus cut-offs and noise
    task automatic test_random_traffic(input int target);
        t_in_req r;
        int      pick;
        int      len;
        int      stop_at;
        int      goal;
        goal = items_sent + target;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                len     = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 10);
                stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) : len;
                r = rand_req(ACT_HEADER);
                r.payload_length = 16'(len);
                send_req(r);
                for (int i = 0; i < stop_at; i++) send_req(rand_req(ACT_DATA));
            end else if (pick < 80) begin
                send_req(rand_req(ACT_ACK));
            end else if (pick < 88) begin
                // any length, usually left unfinished
                r = rand_req(ACT_HEADER);
                r.payload_length = 16'($urandom);
                send_req(r);
                repeat ($urandom_range(1, 3)) send_req(rand_req(ACT_DATA));
            end else if (pick < 95) begin
                send_req(rand_req(ACT_DATA));
            end else begin
                send_req(rand_req(ACT_NONE));
            end
        end
    endtask

    // sender holds off mid-frame until the output has caught up, then finishes the frame
    task automatic test_pressure_pause;
        t_in_req r;
        r = rand_req(ACT_HEADER);
        r.payload_length = 16'd6;
        send_req(r);
        repeat (3) send_req(rand_req(ACT_DATA));
        drain_bytes();
        repeat (3) send_req(rand_req(ACT_DATA));
    endtask

    // last stretch without any idling on either side
    task automatic test_quiet_tail;
        drain_bytes();
        quiet = 1'b1;
        test_random_traffic(40);
    endtask

    initial begin
        cfg_model[REG_SYNC_FIRST]  = 8'hAA;
        cfg_model[REG_SYNC_SECOND] = 8'h55;
        cfg_model[REG_ACK_VERSION] = 8'h01;
        cfg_model[REG_ACK_COMMAND] = 8'h80;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_frames();
        test_config_extremes();
        apply_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        test_random_traffic(130);
        test_pressure_pause();
        apply_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        test_random_traffic(120);
        test_quiet_tail();

        drain_bytes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (frame_bytes_q.size() != 0)
            report_mismatch("bytes never produced", 32'(frame_bytes_q.size()), 32'h0);
        if (mismatches == 0) begin
            $display("tlv_frame_builder_crc16 regression: pass");
        end else begin
            $display("tlv_frame_builder_crc16 regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/tfb_pkg.sv
rtl/tfb_cfg.sv
rtl/tfb_ctrl.sv
rtl/tfb_ser.sv
rtl/tlv_frame_builder_crc16.sv
test/tb_top.sv
